// ===== design/krt_pkg.sv =====
// Shared types and constants of the keyed route table.
package krt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // Field widths
  localparam int KIND_W    = 2;
  localparam int KEY_W     = 64;
  localparam int DATA_W    = 32;
  localparam int OUTCOME_W = 2;
  localparam int SLOT_W    = 4;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_UPDATE = 2'd0,
    KIND_PIN    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_FIND   = 2'd3
  } kind_t;

  // Outcome codes
  typedef enum logic [OUTCOME_W-1:0] {
    OUT_DONE    = 2'd0,
    OUT_REFUSED = 2'd1,
    OUT_FULL    = 2'd2,
    OUT_MISSING = 2'd3
  } outcome_t;

  // One table entry as held in the entry RAM
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] data;
    logic              pinned;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== design/keyed_route_table_unit.sv =====
// Keyed route table: 64-bit keyed link descriptor table with pinned entries.
//
// Each request is accepted and then compares the entries one at a time, from
// slot 0 up to the first match (or up to the entry count on a miss, at least one);
// a remove that hits then fetches the last entry. The scan pace is set by the single
// read port of the entry RAM feeding one shared 64-bit key comparator. in_stall is
// high while a request is in work; the result sits in an output register, so a new
// request is taken while the previous result still waits on out_stall, and the next
// result waits until that register is free. The entry RAM needs no clearing after
// reset.
module keyed_route_table_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [krt_pkg::KIND_W-1:0]   in_kind,
  input  logic [krt_pkg::KEY_W-1:0]    in_key,
  input  logic [krt_pkg::DATA_W-1:0]   in_link_data,
  input  logic                         in_link_pinned,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [krt_pkg::OUTCOME_W-1:0] out_outcome,
  output logic [krt_pkg::SLOT_W-1:0]   out_slot,
  output logic [krt_pkg::DATA_W-1:0]   out_found_data,
  output logic                         out_found_pinned
);
  import krt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_MOVE = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  hit_r, hit_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Request held while the sequencer works
  kind_t             kind_r;
  logic [KEY_W-1:0]  key_r;
  logic [DATA_W-1:0] data_r;
  logic              pin_r;

  // Result register
  logic              out_valid_r;
  outcome_t          outcome_r;
  logic [SLOT_W-1:0] slot_r;
  logic [DATA_W-1:0] fdata_r;
  logic              fpin_r;

  // RAM port signals
  logic               we;
  logic [IDX_W-1:0]   waddr, rd_addr;
  entry_t             wdata;
  logic [ENTRY_W-1:0] rd_raw;
  entry_t             rd_ent;

  // Result load
  logic              load;
  outcome_t          res_outcome;
  logic [SLOT_W-1:0] res_slot;
  logic [DATA_W-1:0] res_data;
  logic              res_pin;

  logic              accept, out_free, match, last_scan;
  logic [CNT_W-1:0]  cnt_dec;
  logic [IDX_W-1:0]  last_idx;
  entry_t            new_ent;

  krt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  assign rd_ent   = entry_t'(rd_raw);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Shared key compare and scan-end test
  assign match     = (cnt_r != '0) && (rd_ent.key == key_r);
  assign last_scan = (CNT_W'(idx_r) + CNT_W'(1)) >= cnt_r;
  assign cnt_dec   = cnt_r - CNT_W'(1);
  assign last_idx  = IDX_W'(cnt_dec);

  always_comb begin
    new_ent.key    = key_r;
    new_ent.data   = data_r;
    new_ent.pinned = pin_r;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    hit_nxt     = hit_r;
    cnt_nxt     = cnt_r;
    rd_addr     = idx_r;
    we          = 1'b0;
    waddr       = idx_r;
    wdata       = new_ent;
    load        = 1'b0;
    res_outcome = OUT_DONE;
    res_slot    = '0;
    res_data    = '0;
    res_pin     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
          rd_addr   = '0;
        end
      end
      ST_SCAN: begin
        if (match) begin
          if (kind_r == KIND_REMOVE) begin
            // fetch the last entry to fill the freed slot
            hit_nxt   = idx_r;
            rd_addr   = last_idx;
            state_nxt = ST_MOVE;
          end else if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
            res_slot  = SLOT_W'(idx_r);
            case (kind_r)
              KIND_UPDATE: begin
                if (rd_ent.pinned) begin
                  res_outcome = OUT_REFUSED;
                  res_slot    = '0;
                end else begin
                  we = 1'b1;
                end
              end
              KIND_PIN: begin
                we           = 1'b1;
                wdata        = rd_ent;
                wdata.pinned = 1'b1;
              end
              KIND_FIND: begin
                res_data = rd_ent.data;
                res_pin  = rd_ent.pinned;
              end
              default: begin
                res_outcome = OUT_DONE;
              end
            endcase
          end
        end else if (last_scan) begin
          if (out_free) begin
            load      = 1'b1;
            state_nxt = ST_IDLE;
            if (kind_r == KIND_UPDATE) begin
              if (cnt_r < CNT_W'(TABLE_DEPTH)) begin
                // append a new entry
                we       = 1'b1;
                waddr    = IDX_W'(cnt_r);
                res_slot = SLOT_W'(cnt_r);
                cnt_nxt  = cnt_r + CNT_W'(1);
              end else begin
                res_outcome = OUT_FULL;
              end
            end else begin
              res_outcome = OUT_MISSING;
            end
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
          rd_addr = idx_r + IDX_W'(1);
        end
      end
      ST_MOVE: begin
        rd_addr = last_idx;
        if (out_free) begin
          we        = 1'b1;
          waddr     = hit_r;
          wdata     = rd_ent;
          cnt_nxt   = cnt_dec;
          load      = 1'b1;
          res_slot  = SLOT_W'(hit_r);
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    if (accept) begin
      kind_r <= kind_t'(in_kind);
      key_r  <= in_key;
      data_r <= in_link_data;
      pin_r  <= in_link_pinned;
    end
    if (load) begin
      outcome_r <= res_outcome;
      slot_r    <= res_slot;
      fdata_r   <= res_data;
      fpin_r    <= res_pin;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_slot         = slot_r;
  assign out_found_data   = fdata_r;
  assign out_found_pinned = fpin_r;

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_we_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r != ST_IDLE))
    else $error("entry write while idle");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN))
    else $error("accepted request did not start a scan");

endmodule

// ===== design/krt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/tb_keyed_route_table_unit.sv =====
`timescale 1ns / 100ps
// Testbench for keyed_route_table_unit: directed and random requests checked against a shadow table.
module tb_keyed_route_table_unit;
  import krt_pkg::*;

  localparam int POOL_SIZE = 24;

  // Expected reply of one request
  typedef struct {
    outcome_t          outcome;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
    logic              pinned;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [KEY_W-1:0]     in_key = '0;
  logic [DATA_W-1:0]    in_link_data = '0;
  logic                 in_link_pinned = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [OUTCOME_W-1:0] out_outcome;
  logic [SLOT_W-1:0]    out_slot;
  logic [DATA_W-1:0]    out_found_data;
  logic                 out_found_pinned;

  // Shadow copy of the table
  logic [KEY_W-1:0]  shadow_key [TABLE_DEPTH];
  logic [DATA_W-1:0] shadow_data [TABLE_DEPTH];
  logic              shadow_pin [TABLE_DEPTH];
  int                entry_total = 0;

  logic [KEY_W-1:0]  key_pool [POOL_SIZE];
  reply_t            pending_replies [$];
  int                fail_count = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;

  keyed_route_table_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_key           (in_key),
    .in_link_data     (in_link_data),
    .in_link_pinned   (in_link_pinned),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_outcome      (out_outcome),
    .out_slot         (out_slot),
    .out_found_data   (out_found_data),
    .out_found_pinned (out_found_pinned)
  );

  always #10 clk = ~clk;

  // Random back-pressure on the reply side
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Apply one request to the shadow table and return the reply it should give
  function automatic reply_t apply_request(kind_t kind, logic [KEY_W-1:0] key,
                                           logic [DATA_W-1:0] ldata, logic lpin);
    reply_t r;
    int     hit;
    int     last;
    r = '{outcome: OUT_DONE, slot: '0, data: '0, pinned: 1'b0};
    hit = -1;
    for (int i = 0; i < entry_total; i++) begin
      if (hit < 0 && shadow_key[i] == key) hit = i;
    end
    if (kind == KIND_UPDATE) begin
      if (hit >= 0) begin
        if (shadow_pin[hit]) begin
          r.outcome = OUT_REFUSED;
        end else begin
          shadow_data[hit] = ldata;
          shadow_pin[hit] = lpin;
          r.slot = SLOT_W'(hit);
        end
      end else if (entry_total < TABLE_DEPTH) begin
        shadow_key[entry_total] = key;
        shadow_data[entry_total] = ldata;
        shadow_pin[entry_total] = lpin;
        r.slot = SLOT_W'(entry_total);
        entry_total++;
      end else begin
        r.outcome = OUT_FULL;
      end
    end else if (hit < 0) begin
      r.outcome = OUT_MISSING;
    end else begin
      r.slot = SLOT_W'(hit);
      case (kind)
        KIND_PIN: begin
          shadow_pin[hit] = 1'b1;
        end
        KIND_REMOVE: begin
          // last entry fills the hole
          last = entry_total - 1;
          shadow_key[hit] = shadow_key[last];
          shadow_data[hit] = shadow_data[last];
          shadow_pin[hit] = shadow_pin[last];
          entry_total = last;
        end
        default: begin
          r.data = shadow_data[hit];
          r.pinned = shadow_pin[hit];
        end
      endcase
    end
    return r;
  endfunction

  // Key mix: mostly live entries, some pool keys, some fresh, a few one-bit misses
  function automatic logic [KEY_W-1:0] choose_key();
    logic [KEY_W-1:0] k;
    int               roll;
    roll = $urandom_range(99);
    if (entry_total > 0 && roll < 65) k = shadow_key[$urandom_range(entry_total - 1)];
    else if (roll < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
    else k = {$urandom(), $urandom()};
    if ($urandom_range(19) == 0) k[$urandom_range(KEY_W - 1)] ^= 1'b1;
    return k;
  endfunction

  // Drive one request and wait until it is taken
  task automatic issue_request(kind_t kind, logic [KEY_W-1:0] key,
                               logic [DATA_W-1:0] ldata, logic lpin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_link_data <= ldata;
    in_link_pinned <= lpin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_replies.push_back(apply_request(kind, key, ldata, lpin));
  endtask

  // Hold off new requests until every reply is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Reply checker
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding");
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (out_outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
          fail_count++;
        end
        if (out_slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, out_slot);
          fail_count++;
        end
        if (out_found_data !== want.data) begin
          $error("found_data: expected %h, got %h", want.data, out_found_data);
          fail_count++;
        end
        if (out_found_pinned !== want.pinned) begin
          $error("found_pinned: expected %b, got %b", want.pinned, out_found_pinned);
          fail_count++;
        end
      end
    end
  end

  // Every lookup on an empty table misses
  task automatic test_empty_table();
    issue_request(KIND_FIND, '0, '1, 1'b1);
    issue_request(KIND_PIN, '1, '0, 1'b0);
    issue_request(KIND_REMOVE, 64'h0123_4567_89AB_CDEF, 32'h5555_AAAA, 1'b1);
  endtask

  // Insert, replace, refuse on pinned, pin twice, find
  task automatic test_update_and_pin();
    issue_request(KIND_UPDATE, '0, '0, 1'b0);
    issue_request(KIND_UPDATE, '1, '1, 1'b1);
    issue_request(KIND_UPDATE, '0, 32'hA5A5_5A5A, 1'b0);
    issue_request(KIND_UPDATE, '1, 32'h1234_5678, 1'b0);
    issue_request(KIND_PIN, '0, 32'hDEAD_BEEF, 1'b0);
    issue_request(KIND_PIN, '0, '0, 1'b1);
    issue_request(KIND_UPDATE, '0, 32'h0F0F_0F0F, 1'b0);
    issue_request(KIND_FIND, '1, '0, 1'b0);
    issue_request(KIND_FIND, '0, '1, 1'b0);
    // top bit differs from a live key
    issue_request(KIND_FIND, 64'h8000_0000_0000_0000, '0, 1'b0);
    issue_request(KIND_UPDATE, 64'h0000_0000_0000_0001, 32'h8000_0001, 1'b0);
  endtask

  // Remove from the middle moves the last entry; removing the last moves nothing
  task automatic test_remove_moves_last();
    issue_request(KIND_REMOVE, '0, '1, 1'b1);
    issue_request(KIND_FIND, 64'h0000_0000_0000_0001, '0, 1'b0);
    issue_request(KIND_REMOVE, '1, '0, 1'b0);
    issue_request(KIND_REMOVE, '1, '0, 1'b0);
    issue_request(KIND_FIND, 64'h0000_0000_0000_0001, '0, 1'b0);
    issue_request(KIND_REMOVE, 64'h0000_0000_0000_0001, '0, 1'b0);
  endtask

  // Fill to capacity, overflow, read back, then drain in random order
  task automatic test_table_full();
    logic [KEY_W-1:0] k;
    while (entry_total < TABLE_DEPTH) begin
      issue_request(KIND_UPDATE, {$urandom(), $urandom()}, $urandom(), 1'($urandom()));
    end
    issue_request(KIND_UPDATE, {$urandom(), $urandom()}, $urandom(), 1'b0);
    issue_request(KIND_UPDATE, shadow_key[TABLE_DEPTH - 1], $urandom(), 1'b0);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      issue_request(KIND_FIND, shadow_key[i], $urandom(), 1'($urandom()));
    end
    while (entry_total > 0) begin
      k = shadow_key[$urandom_range(entry_total - 1)];
      issue_request(KIND_REMOVE, k, $urandom(), 1'($urandom()));
    end
  endtask

  // Mixed traffic, alternating growth and shrink so the count sweeps its range
  task automatic test_random_traffic(int count);
    int    roll;
    bit    grow;
    kind_t kind;
    for (int i = 0; i < count; i++) begin
      grow = ((i / 40) % 2) == 0;
      roll = $urandom_range(99);
      if (roll < (grow ? 50 : 20)) kind = KIND_UPDATE;
      else if (roll < (grow ? 60 : 30)) kind = KIND_PIN;
      else if (roll < (grow ? 75 : 70)) kind = KIND_REMOVE;
      else kind = KIND_FIND;
      issue_request(kind, choose_key(), $urandom(), $urandom_range(3) == 0);
      if ($urandom_range(99) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom(), $urandom()};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_update_and_pin();
    test_remove_moves_last();
    wait_drained();

    idle_pct = 32;
    stall_pct = 32;
    test_table_full();
    wait_drained();

    idle_pct = 0;
    stall_pct = 0;
    test_random_traffic(230);
    idle_pct = 52;
    test_random_traffic(230);
    idle_pct = 0;
    stall_pct = 52;
    test_random_traffic(230);
    idle_pct = 32;
    stall_pct = 32;
    test_random_traffic(230);

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
